// ===== sv/open_file_usage_table_assert.svh =====
// Assertion macros for the open file usage table.
`ifndef OPEN_FILE_USAGE_TABLE_ASSERT_SVH
`define OPEN_FILE_USAGE_TABLE_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Checked only while out of reset.
`define OFUT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define OFUT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define OFUT_ASSERT(lbl, clk, rst_n, prop, msg)
`define OFUT_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== sv/ofut_pkg.sv =====
package ofut_pkg;

    localparam int KEY_BITS = 64;

    // request codes
    localparam logic [2:0] REQ_OPEN  = 3'd0;
    localparam logic [2:0] REQ_CLOSE = 3'd1;
    localparam logic [2:0] REQ_START = 3'd2;
    localparam logic [2:0] REQ_STOP  = 3'd3;
    localparam logic [2:0] REQ_DIRTY = 3'd4;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RETRY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_ERROR = 2'd3;

    // close codes
    localparam logic [1:0] CC_LAST_OPENER = 2'd0;
    localparam logic [1:0] CC_LAST_WRITER = 2'd1;
    localparam logic [1:0] CC_UNCHANGED   = 2'd2;

    typedef struct packed {
        logic [2:0]          req_type;
        logic [KEY_BITS-1:0] file_id;
        logic                for_write;
    } t_req;

    typedef struct packed {
        logic [1:0] status;
        logic [1:0] close_code;
        logic       was_clean;
        logic       granted;
    } t_rsp;

endpackage

// ===== sv/ofut_stream_if.sv =====
interface ofut_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/open_file_usage_table.sv =====
// Open file usage table. Each request transfer on i_req is looked up by file_id with a linear
// search of the single-port entry memory, one entry read per cycle; the read-modify-write then
// follows and the result lands in an output register on o_rsp, so the next request is
// taken while a result still waits. A hit ends the search at its slot, a miss (new entry or
// full table) reads every entry, and a request of unknown type skips the search. After reset
// a clearing pass over every entry invalidates the memory before the first request is taken.
`include "open_file_usage_table_assert.svh"

module open_file_usage_table #(
    parameter int TABLE_ENTRIES = 64,
    parameter int COUNT_BITS    = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    ofut_stream_if.sink          i_req,
    ofut_stream_if.source        o_rsp
);
    import ofut_pkg::*;

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam logic [AW:0] DEPTH     = (AW+1)'(TABLE_ENTRIES);
    localparam logic [AW:0] LAST_ADDR = (AW+1)'(TABLE_ENTRIES - 1);
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

    typedef struct packed {
        logic                  valid;
        logic [KEY_BITS-1:0]   key;
        logic [COUNT_BITS-1:0] open_cnt;
        logic [COUNT_BITS-1:0] wr_cnt;
        logic [COUNT_BITS-1:0] lk_cnt;
        logic                  clean;
    } t_entry;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_COMMIT
    } t_state;

    t_state r_state;

    t_entry r_mem [TABLE_ENTRIES];
    t_entry r_mem_q;

    logic [AW:0]           r_addr;
    logic                  r_rd_vld;
    logic                  r_rd_last;
    logic [AW-1:0]         r_rd_idx;
    logic                  r_free_vld;
    logic [AW-1:0]         r_free_idx;

    t_req                  r_req;
    logic                  r_skip;
    logic                  r_full;
    logic [AW-1:0]         r_slot;
    logic [COUNT_BITS-1:0] r_cnt;
    logic [COUNT_BITS-1:0] r_wc;
    logic [COUNT_BITS-1:0] r_lc;
    logic                  r_cl;

    logic                  r_out_valid;
    t_rsp                  r_rsp;

    logic                  rd_issue;
    logic                  hit;
    logic                  free_now;
    logic                  commit_go;
    logic                  mem_we;
    logic [AW-1:0]         wr_addr;
    t_entry                wr_data;

    t_rsp                  n_rsp;
    logic [COUNT_BITS-1:0] n_cnt;
    logic [COUNT_BITS-1:0] n_wc;
    logic [COUNT_BITS-1:0] n_lc;
    logic                  n_cl;
    logic                  release_ent;
    t_entry                n_entry;

    assign i_req.ready  = (r_state == S_IDLE);
    assign o_rsp.valid  = r_out_valid;
    assign o_rsp.data   = r_rsp;

    assign rd_issue  = (r_state == S_SCAN) && (r_addr != DEPTH);
    assign hit       = r_rd_vld && r_mem_q.valid && (r_mem_q.key == r_req.file_id);
    assign free_now  = r_rd_vld && !r_mem_q.valid;
    assign commit_go = (r_state == S_COMMIT) && (!r_out_valid || o_rsp.ready);

    // request against the found or fresh entry
    always_comb begin
        n_rsp.status     = ST_OK;
        n_rsp.close_code = CC_UNCHANGED;
        n_rsp.was_clean  = 1'b1;
        n_rsp.granted    = 1'b0;
        n_cnt = r_cnt;
        n_wc  = r_wc;
        n_lc  = r_lc;
        n_cl  = r_cl;
        if (r_skip) begin
            n_rsp.status = ST_OK;
        end else if (r_full) begin
            n_rsp.status = ST_FULL;
        end else begin
            unique case (r_req.req_type)
                REQ_OPEN: begin
                    if (r_cnt == CNT_MAX || (r_req.for_write && r_wc == CNT_MAX)) begin
                        n_rsp.status = ST_ERROR;
                    end else begin
                        n_cnt = r_cnt + CNT_ONE;
                        if (r_req.for_write) begin
                            n_wc = r_wc + CNT_ONE;
                        end
                    end
                end
                REQ_CLOSE: begin
                    if (r_cnt == '0 || (r_req.for_write && r_wc == '0)) begin
                        n_rsp.status = ST_ERROR;
                    end else begin
                        if (r_req.for_write) begin
                            n_rsp.was_clean = r_cl;
                            n_wc = r_wc - CNT_ONE;
                            if (r_wc == CNT_ONE) begin
                                n_rsp.close_code = CC_LAST_WRITER;
                                n_cl = 1'b1;
                            end
                        end
                        n_cnt = r_cnt - CNT_ONE;
                        if (r_cnt == CNT_ONE) begin
                            n_rsp.close_code = CC_LAST_OPENER;
                        end
                    end
                end
                REQ_START: begin
                    if (r_cl) begin
                        if (r_lc == CNT_MAX) begin
                            n_rsp.status = ST_ERROR;
                        end else begin
                            n_lc = r_lc + CNT_ONE;
                            n_rsp.granted = 1'b1;
                        end
                    end
                end
                REQ_STOP: begin
                    if (r_lc == '0) begin
                        n_rsp.status = ST_ERROR;
                    end else begin
                        n_lc = r_lc - CNT_ONE;
                    end
                end
                REQ_DIRTY: begin
                    if (r_cl) begin
                        if (r_lc != '0) begin
                            n_rsp.status = ST_RETRY;
                        end else begin
                            n_cl = 1'b0;
                        end
                    end
                end
                default: begin
                    n_rsp.status = ST_OK;
                end
            endcase
        end
    end

    assign release_ent = ((r_req.req_type == REQ_CLOSE) || (r_req.req_type == REQ_STOP))
                         && (n_cnt == '0) && (n_lc == '0);

    always_comb begin
        n_entry.valid    = !release_ent;
        n_entry.key      = r_req.file_id;
        n_entry.open_cnt = n_cnt;
        n_entry.wr_cnt   = n_wc;
        n_entry.lk_cnt   = n_lc;
        n_entry.clean    = n_cl;
    end

    assign mem_we  = (r_state == S_CLEAR)
                     || (commit_go && !r_skip && !r_full && (n_rsp.status == ST_OK));
    assign wr_addr = (r_state == S_CLEAR) ? r_addr[AW-1:0] : r_slot;
    assign wr_data = (r_state == S_CLEAR) ? t_entry'('0) : n_entry;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_issue) begin
            r_mem_q <= r_mem[r_addr[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_addr      <= '0;
            r_rd_vld    <= 1'b0;
            r_free_vld  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_rsp.ready && !commit_go) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_addr <= r_addr + (AW+1)'(1);
                    if (r_addr == LAST_ADDR) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_req      <= i_req.data;
                        r_addr     <= '0;
                        r_rd_vld   <= 1'b0;
                        r_free_vld <= 1'b0;
                        r_full     <= 1'b0;
                        r_skip     <= (i_req.data.req_type > REQ_DIRTY);
                        r_state    <= (i_req.data.req_type > REQ_DIRTY) ? S_COMMIT : S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_rd_vld  <= rd_issue;
                    r_rd_idx  <= r_addr[AW-1:0];
                    r_rd_last <= (r_addr == LAST_ADDR);
                    if (rd_issue) begin
                        r_addr <= r_addr + (AW+1)'(1);
                    end
                    if (hit) begin
                        r_slot  <= r_rd_idx;
                        r_cnt   <= r_mem_q.open_cnt;
                        r_wc    <= r_mem_q.wr_cnt;
                        r_lc    <= r_mem_q.lk_cnt;
                        r_cl    <= r_mem_q.clean;
                        r_state <= S_COMMIT;
                    end else begin
                        if (free_now && !r_free_vld) begin
                            r_free_vld <= 1'b1;
                            r_free_idx <= r_rd_idx;
                        end
                        // key absent: take the lowest free slot seen
                        if (r_rd_vld && r_rd_last) begin
                            r_full  <= !(r_free_vld || free_now);
                            r_slot  <= r_free_vld ? r_free_idx : r_rd_idx;
                            r_cnt   <= '0;
                            r_wc    <= '0;
                            r_lc    <= '0;
                            r_cl    <= 1'b1;
                            r_state <= S_COMMIT;
                        end
                    end
                end
                S_COMMIT: begin
                    if (commit_go) begin
                        r_out_valid <= 1'b1;
                        r_rsp       <= n_rsp;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_CLEAR;
                end
            endcase
        end
    end

    `OFUT_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> r_state == S_CLEAR, "no clearing pass after reset")
    `OFUT_ASSERT(a_rsp_from_commit, i_clk, i_rst_n, $rose(r_out_valid) |-> $past(r_state == S_COMMIT), "result without commit")
    `OFUT_ASSERT(a_write_only_ok, i_clk, i_rst_n, (mem_we && r_state == S_COMMIT) |-> (n_rsp.status == ST_OK), "entry written on a flagged request")
    `OFUT_ASSERT(a_rsp_held, i_clk, i_rst_n, (r_out_valid && !o_rsp.ready) |=> (r_out_valid && $stable(r_rsp)), "waiting result dropped or changed")

endmodule
